@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the Hough line vote accumulator.
// Standalone header; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset.
`define HLVA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication under an active-low reset.
`define HLVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define HLVA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HLVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/hlva_pkg.sv @@
// Package of the Hough line vote accumulator: opcodes, chain token type,
// default sizes and the Q16 sine table. No dependencies.
package hlva_pkg;

    localparam int RHO_BINS_DEF    = 181;
    localparam int ANGLE_STEPS_DEF = 90;
    localparam int ROM_ANGLES      = 90;
    localparam int COUNT_W         = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_VOTE  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Transaction traveling along the cell chain.
    typedef struct packed {
        logic               vld;
        op_t                op;
        logic [7:0]         row;
        logic [7:0]         col;
        logic [7:0]         rrho;
        logic [6:0]         rang;
        logic [COUNT_W-1:0] count;
    } token_t;

    // round(65536 * sin(2k degrees)), k = 0..45
    localparam int SIN_ROM [46] = '{
            0,  2287,  4572,  6850,  9121, 11380, 13626, 15855,
        18064, 20252, 22415, 24550, 26656, 28729, 30767, 32768,
        34729, 36647, 38521, 40348, 42126, 43852, 45525, 47143,
        48703, 50203, 51643, 53020, 54332, 55578, 56756, 57865,
        58903, 59870, 60764, 61584, 62328, 62997, 63589, 64104,
        64540, 64898, 65177, 65376, 65496, 65536
    };

    function automatic int rom_sin(int k);
        return (k <= 45) ? SIN_ROM[k] : SIN_ROM[90 - k];
    endfunction

    function automatic int rom_cos(int k);
        return (k <= 45) ? SIN_ROM[45 - k] : -SIN_ROM[k - 45];
    endfunction

endpackage

@@ rtl/hlva_in_if.sv @@
// Input channel of the Hough line vote accumulator: valid/ready plus one item.
// Depends on nothing.
interface hlva_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic       is_edge;
    logic [7:0] read_rho;
    logic [6:0] read_angle;

    modport source (output valid, opcode, pixel_row, pixel_col, is_edge, read_rho,
                    read_angle, input ready);
    modport sink   (input valid, opcode, pixel_row, pixel_col, is_edge, read_rho,
                    read_angle, output ready);
endinterface

@@ rtl/hlva_out_if.sv @@
// Result channel of the Hough line vote accumulator: valid/ready plus one result.
// Depends on nothing.
interface hlva_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] bin_count;
    logic       is_read_reply;

    modport source (output valid, bin_count, is_read_reply, input ready);
    modport sink   (input valid, bin_count, is_read_reply, output ready);
endinterface

@@ rtl/hough_line_vote_accumulator.sv @@
// Hough line vote accumulator. A vote or read transaction walks a chain of
// ANGLE_STEPS cells, through s1_reg and then out_reg of each cell, and its
// result passes the pending and then the output register; each cell
// holds the RHO_BINS counters of one angle in a local memory and does one
// read-modify-write as the vote passes. One transaction is in the chain at a
// time. A clear, and the pass that follows reset, sweeps all cell memories in
// parallel, one rho row per cycle, and no item is taken until it ends. Non-edge
// votes and unused opcodes skip the chain and answer from the pending register.
// Depends on hlva_pkg, hlva_in_if, hlva_out_if, hlva_cell, assert_macros.svh.
`include "assert_macros.svh"

module hough_line_vote_accumulator #(
    parameter int RHO_BINS    = hlva_pkg::RHO_BINS_DEF,
    parameter int ANGLE_STEPS = hlva_pkg::ANGLE_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hlva_in_if.sink     item,
    hlva_out_if.source  result
);

    localparam int AW = (RHO_BINS > 1) ? $clog2(RHO_BINS) : 1;

    hlva_pkg::token_t chain [ANGLE_STEPS+1];

    hlva_pkg::token_t             launch_reg;
    logic                         busy_reg;
    logic                         clr_active_reg;
    logic [AW-1:0]                clr_addr_reg;
    logic                         pend_vld_reg;
    logic [hlva_pkg::COUNT_W-1:0] pend_count_reg;
    logic                         pend_reply_reg;
    logic                         out_vld_reg;
    logic [hlva_pkg::COUNT_W-1:0] out_count_reg;
    logic                         out_reply_reg;

    logic          accept;
    logic          out_free;
    logic          clr_last;
    hlva_pkg::op_t in_op;
    logic          to_chain;

    assign in_op    = hlva_pkg::op_t'(item.opcode);
    assign accept   = item.valid && item.ready;
    assign out_free = !out_vld_reg || result.ready;
    assign clr_last = (clr_addr_reg == AW'(RHO_BINS - 1));
    // Edge votes and reads walk the chain; a clear sweeps, the rest go to pending.
    assign to_chain = ((in_op == hlva_pkg::OP_VOTE) && item.is_edge)
                      || (in_op == hlva_pkg::OP_READ);

    assign item.ready          = !busy_reg && !clr_active_reg;
    assign result.valid        = out_vld_reg;
    assign result.bin_count    = out_count_reg;
    assign result.is_read_reply = out_reply_reg;

    assign chain[0] = launch_reg;

    for (genvar a = 0; a < ANGLE_STEPS; a++)
    begin : g_cell
        hlva_cell #(
            .ANGLE_IDX (a),
            .RHO_BINS  (RHO_BINS),
            .AW        (AW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (chain[a]),
            .tok_out  (chain[a+1]),
            .clr_en   (clr_active_reg),
            .clr_addr (clr_addr_reg)
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg     <= '0;
            busy_reg       <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            pend_vld_reg   <= 1'b0;
            pend_count_reg <= '0;
            pend_reply_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_count_reg  <= '0;
            out_reply_reg  <= 1'b0;
        end
        else
        begin
            launch_reg.vld <= 1'b0;

            // Advance the pending result into the output register when free.
            if (pend_vld_reg && out_free)
            begin
                out_vld_reg   <= 1'b1;
                out_count_reg <= pend_count_reg;
                out_reply_reg <= pend_reply_reg;
                pend_vld_reg  <= 1'b0;
                busy_reg      <= 1'b0;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (accept)
            begin
                busy_reg <= 1'b1;
                if (to_chain)
                begin
                    launch_reg.vld   <= 1'b1;
                    launch_reg.op    <= in_op;
                    launch_reg.row   <= item.pixel_row;
                    launch_reg.col   <= item.pixel_col;
                    launch_reg.rrho  <= item.read_rho;
                    launch_reg.rang  <= item.read_angle;
                    launch_reg.count <= '0;
                end
                else if (in_op == hlva_pkg::OP_CLEAR)
                begin
                    clr_active_reg <= 1'b1;
                    clr_addr_reg   <= '0;
                end
                else
                begin
                    pend_vld_reg   <= 1'b1;
                    pend_count_reg <= '0;
                    pend_reply_reg <= 1'b0;
                end
            end

            // Sweep one rho row per cycle; answer only an accepted clear.
            if (clr_active_reg)
            begin
                if (clr_last)
                begin
                    clr_active_reg <= 1'b0;
                    if (busy_reg)
                    begin
                        pend_vld_reg   <= 1'b1;
                        pend_count_reg <= '0;
                        pend_reply_reg <= 1'b0;
                    end
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end

            // Hold the transaction leaving the last cell as the pending result.
            if (chain[ANGLE_STEPS].vld)
            begin
                pend_vld_reg   <= 1'b1;
                pend_count_reg <= chain[ANGLE_STEPS].count;
                pend_reply_reg <= (chain[ANGLE_STEPS].op == hlva_pkg::OP_READ);
            end
        end
    end

    `HLVA_ASSERT_IMP(a_exit_in_flight, clk, rst_n, chain[ANGLE_STEPS].vld, busy_reg && !clr_active_reg && !pend_vld_reg)
    `HLVA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    `HLVA_ASSERT_IMP(a_pend_busy, clk, rst_n, pend_vld_reg, busy_reg && !clr_active_reg)

endmodule

@@ rtl/hlva_cell.sv @@
// One angle cell: computes the rho bin for its fixed angle, owns that angle's
// column of vote counters and forwards the transaction. Depends on hlva_pkg.
module hlva_cell #(
    parameter int ANGLE_IDX = 0,
    parameter int RHO_BINS  = hlva_pkg::RHO_BINS_DEF,
    parameter int AW        = $clog2(hlva_pkg::RHO_BINS_DEF)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hlva_pkg::token_t  tok_in,
    output hlva_pkg::token_t  tok_out,
    input  logic              clr_en,
    input  logic [AW-1:0]     clr_addr
);

    localparam int K = ANGLE_IDX % hlva_pkg::ROM_ANGLES;
    localparam logic signed [17:0] SIN_C = 18'(hlva_pkg::rom_sin(K));
    localparam logic signed [17:0] COS_C = 18'(hlva_pkg::rom_cos(K));

    logic [hlva_pkg::COUNT_W-1:0] mem [RHO_BINS];

    logic signed [8:0]  col_s;
    logic signed [8:0]  row_s;
    logic signed [26:0] prod_c;
    logic signed [26:0] prod_s;
    logic signed [27:0] rho;
    logic [27:0]        mag;
    logic [10:0]        rbin;
    logic               vote_hit;
    logic               read_hit;
    logic [AW-1:0]      raddr;
    logic [hlva_pkg::COUNT_W-1:0] inc;

    hlva_pkg::token_t             s1_reg;
    hlva_pkg::token_t             out_reg;
    logic                         wr_reg;
    logic                         rd_hit_reg;
    logic [AW-1:0]                waddr_reg;
    logic [hlva_pkg::COUNT_W-1:0] rdata_reg;

    // rho = col*cos + row*sin in signed Q12.16, bin = |rho| / 2^17
    always_comb
    begin
        col_s  = $signed({1'b0, tok_in.col});
        row_s  = $signed({1'b0, tok_in.row});
        prod_c = 27'(col_s) * 27'(COS_C);
        prod_s = 27'(row_s) * 27'(SIN_C);
        rho    = 28'(prod_c) + 28'(prod_s);
        mag    = rho[27] ? 28'(-rho) : 28'(rho);
        rbin   = mag[27:17];
        vote_hit = tok_in.vld && (tok_in.op == hlva_pkg::OP_VOTE)
                   && (32'(rbin) < RHO_BINS);
        read_hit = tok_in.vld && (tok_in.op == hlva_pkg::OP_READ)
                   && (32'(tok_in.rang) == ANGLE_IDX) && (32'(tok_in.rrho) < RHO_BINS);
        raddr  = (tok_in.op == hlva_pkg::OP_VOTE) ? rbin[AW-1:0] : AW'(tok_in.rrho);
        inc    = (rdata_reg < hlva_pkg::COUNT_MAX) ? rdata_reg + 1'b1 : rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.vld)
        begin
            rdata_reg <= mem[raddr];
        end
        if (clr_en)
        begin
            mem[clr_addr] <= '0;
        end
        else if (wr_reg)
        begin
            mem[waddr_reg] <= inc;
        end
        waddr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg     <= '0;
            out_reg    <= '0;
            wr_reg     <= 1'b0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_reg     <= tok_in;
            wr_reg     <= vote_hit;
            rd_hit_reg <= read_hit;
            out_reg    <= s1_reg;
            if (rd_hit_reg)
            begin
                out_reg.count <= rdata_reg;
            end
        end
    end

    assign tok_out = out_reg;

endmodule

@@ tb/tb_hough_line_vote_accumulator.sv @@
// Testbench of the Hough line vote accumulator: directed and random vote, read
// and clear transactions checked against an in-bench model of the vote store.
// Depends on hlva_pkg, hlva_in_if, hlva_out_if and hough_line_vote_accumulator.
`timescale 1ns / 1ps

module tb_hough_line_vote_accumulator;

    localparam int NRHO = 181;
    localparam int NANG = 90;

    typedef struct packed {
        logic [7:0] bin_count;
        logic       is_read_reply;
    } reply_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   reply_count;
    int   read_count;
    int   vote_count;
    bit   idle_on;
    bit   hold_off;

    hlva_in_if  item ();
    hlva_out_if result ();

    hough_line_vote_accumulator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    // Shadow copy of the vote store and the replies still owed by the block.
    logic [7:0] shadow_bins [NRHO][NANG];
    reply_t     pending_replies [$];

    // Own Q16 sine table, round(65536*sin(2k deg)), k = 0..45.
    int sine_q16 [46] = '{
            0,  2287,  4572,  6850,  9121, 11380, 13626, 15855,
        18064, 20252, 22415, 24550, 26656, 28729, 30767, 32768,
        34729, 36647, 38521, 40348, 42126, 43852, 45525, 47143,
        48703, 50203, 51643, 53020, 54332, 55578, 56756, 57865,
        58903, 59870, 60764, 61584, 62328, 62997, 63589, 64104,
        64540, 64898, 65177, 65376, 65496, 65536
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Apply one transaction to the shadow store and return the expected reply.
    function automatic reply_t predict_reply(hlva_pkg::op_t op, logic [7:0] row,
                                             logic [7:0] col, logic edge_bit,
                                             logic [7:0] rr, logic [6:0] ra);
        reply_t r;
        longint rho;
        longint mag;
        int     s;
        int     c;
        int     rbin;
        r = '0;
        case (op)
            hlva_pkg::OP_VOTE:
            begin
                if (edge_bit)
                begin
                    for (int a = 0; a < NANG; a++)
                    begin
                        s = (a <= 45) ? sine_q16[a] : sine_q16[90 - a];
                        c = (a <= 45) ? sine_q16[45 - a] : -sine_q16[a - 45];
                        rho = longint'(col) * c + longint'(row) * s;
                        mag = (rho < 0) ? -rho : rho;
                        rbin = int'(mag / 131072);
                        if (rbin < NRHO && shadow_bins[rbin][a] != 8'd255)
                            shadow_bins[rbin][a] = shadow_bins[rbin][a] + 8'd1;
                    end
                end
            end
            hlva_pkg::OP_READ:
            begin
                r.is_read_reply = 1'b1;
                if (rr < NRHO && ra < NANG)
                    r.bin_count = shadow_bins[rr][ra];
            end
            hlva_pkg::OP_CLEAR:
            begin
                foreach (shadow_bins[i, j])
                    shadow_bins[i][j] = 8'd0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Idle decision: true with odds 35 in 100 unless the quiet stretch is on.
    function automatic bit take_gap();
        return idle_on && ($urandom_range(99) < 35);
    endfunction

    // Send one transaction; hold it until accepted, then predict its reply.
    task automatic send_item(hlva_pkg::op_t op, logic [7:0] row, logic [7:0] col,
                             logic edge_bit, logic [7:0] rr, logic [6:0] ra);
        while (take_gap())
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid      <= 1'b1;
        item.opcode     <= op;
        item.pixel_row  <= row;
        item.pixel_col  <= col;
        item.is_edge    <= edge_bit;
        item.read_rho   <= rr;
        item.read_angle <= ra;
        do
            @(posedge clk);
        while (!item.ready);
        pending_replies.push_back(predict_reply(op, row, col, edge_bit, rr, ra));
        if (op == hlva_pkg::OP_READ)
            read_count++;
        if (op == hlva_pkg::OP_VOTE && edge_bit)
            vote_count++;
    endtask

    // Drop valid, then wait for every owed reply and a quiet tail.
    task automatic drain();
        item.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= !hold_off && !take_gap();
    end

    // Check each accepted result against the oldest expected reply.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && result.valid && result.ready)
        begin
            reply_count++;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result count=%0d reply=%0b", $time,
                         result.bin_count, result.is_read_reply);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (result.bin_count !== want.bin_count)
                begin
                    $display("%0t: bin_count expected %0d actual %0d", $time,
                             want.bin_count, result.bin_count);
                    error_count++;
                end
                if (result.is_read_reply !== want.is_read_reply)
                begin
                    $display("%0t: is_read_reply expected %0b actual %0b", $time,
                             want.is_read_reply, result.is_read_reply);
                    error_count++;
                end
            end
        end
    end

    // Directed: extremes of every field, each opcode, out-of-range reads
    // and non-edge votes.
    task automatic test_directed();
        send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0);
        send_item(hlva_pkg::OP_VOTE, 8'd0, 8'd0, 1'b1, 8'd0, 7'd0);
        send_item(hlva_pkg::OP_VOTE, 8'd255, 8'd255, 1'b1, 8'd255, 7'd127);
        send_item(hlva_pkg::OP_VOTE, 8'd0, 8'd255, 1'b1, 8'd0, 7'd0);
        send_item(hlva_pkg::OP_VOTE, 8'd255, 8'd0, 1'b1, 8'd0, 7'd0);
        send_item(hlva_pkg::OP_VOTE, 8'd77, 8'd200, 1'b0, 8'd0, 7'd0);
        send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0);
        send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd180, 7'd89);
        send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd181, 7'd0);
        send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd255, 7'd127);
        send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd0, 7'd90);
        send_item(hlva_pkg::OP_NONE, 8'd255, 8'd255, 1'b1, 8'd255, 7'd127);
        send_item(hlva_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0);
        send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0);
        drain();
    endtask

    // Saturate: vote the origin pixel past 255 times, then read the bins.
    task automatic test_saturation();
        for (int i = 0; i < 260; i++)
            send_item(hlva_pkg::OP_VOTE, 8'd0, 8'd0, 1'b1, 8'($urandom), 7'($urandom));
        for (int a = 0; a < 4; a++)
            send_item(hlva_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'd0, 7'(a * 30));
        drain();
    endtask

    // Random mix: votes on rows 0..40, random reads, clears, unused opcodes.
    task automatic test_random();
        int op_pick;
        for (int i = 0; i < 380; i++)
        begin
            idle_on = !(i >= 150 && i < 220);
            op_pick = $urandom_range(99);
            if (op_pick < 50)
                send_item(hlva_pkg::OP_VOTE, 8'($urandom_range(40)), 8'($urandom),
                          ($urandom_range(9) != 0), 8'($urandom), 7'($urandom));
            else if (op_pick < 92)
                send_item(hlva_pkg::OP_READ, 8'($urandom), 8'($urandom), 1'($urandom),
                          8'($urandom_range(190)), 7'($urandom_range(95)));
            else if (op_pick < 95)
                send_item(hlva_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom),
                          8'($urandom), 7'($urandom));
            else
                send_item(hlva_pkg::OP_NONE, 8'($urandom), 8'($urandom), 1'($urandom),
                          8'($urandom), 7'($urandom));
        end
        idle_on = 1'b1;
        drain();
    endtask

    // Hold the receiver off for a long stretch while items keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_item(($urandom_range(1) != 0) ? hlva_pkg::OP_READ
                                                       : hlva_pkg::OP_VOTE,
                              8'($urandom), 8'($urandom), 1'b1,
                              8'($urandom_range(180)), 7'($urandom_range(89)));
            end
        join
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        error_count     = 0;
        reply_count     = 0;
        read_count      = 0;
        vote_count      = 0;
        idle_on         = 1'b1;
        hold_off        = 1'b0;
        item.valid      = 1'b0;
        item.opcode     = hlva_pkg::OP_NONE;
        item.pixel_row  = '0;
        item.pixel_col  = '0;
        item.is_edge    = 1'b0;
        item.read_rho   = '0;
        item.read_angle = '0;
        foreach (shadow_bins[i, j])
            shadow_bins[i][j] = 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_saturation();
        test_backpressure();
        test_random();

        $display("Covered %0d results: %0d edge votes, %0d reads, clears and stalls.",
                 reply_count, vote_count, read_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: bounds the slowest run of roughly 700 items at a 20 ns clock.
    initial
    begin
        #50_000_000;
        $display("Timeout waiting for results.");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
